/* design/linear_probe_hash_table_defines.svh */
// Assertion shorthands for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Plain property, disabled while in reset.
`define LPHT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, disabled while in reset.
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* design/lpht_pkg.sv */
package lpht_pkg;

  // SLOTS must be a power of two; slot indexes wrap modulo SLOTS
  localparam int SLOTS       = 64;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int UCNT_W      = $clog2(SLOTS + 1);
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int HASH_W      = 32;
  localparam int START_W     = 7;
  localparam int NEXT_W      = 8;
  localparam int MOD_W       = 32;
  localparam int LIMIT_W     = 6;
  localparam int LIMIT_RESET = 48;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    ACT_GET  = 2'd0,
    ACT_SET  = 2'd1,
    ACT_DEL  = 2'd2,
    ACT_ITER = 2'd3
  } action_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    tag_t             wr_tag;
  } tag_req_t;

endpackage

/* design/lpht_ram.sv */
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/lpht_tag_store.sv */
module lpht_tag_store
  import lpht_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  tag_req_t req,
  output tag_t     rd_tag
);

  logic [SLOTS-1:0] valid_r;
  logic             valid_q_r;
  logic [1:0]       raw_tag;

  // slots never written since reset read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
    if (req.rd_en) begin
      valid_q_r <= valid_r[req.rd_addr];
    end
  end

  lpht_ram #(
    .WIDTH ($bits(tag_t)),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_addr),
    .wdata (req.wr_tag),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (raw_tag)
  );

  assign rd_tag = valid_q_r ? tag_t'(raw_tag) : TAG_EMPTY;

endmodule

/* design/linear_probe_hash_table.sv */
// Open-addressing key/value table, 64 slots, linear probing with tombstones.
// Slot tags and key/value pairs sit in single-port-read memories; one slot is
// examined per clock, its read address issued in the cycle before. A new
// request is accepted only once the previous one has delivered its result; a
// get or delete on an empty table, a set over the load limit and an iterate
// starting past the last slot skip the probe. An iterate scans from
// start_index towards the last slot and stops at the first used slot. The
// result register lets a new request in while the previous result waits. Tags
// reset to empty at once through per-slot valid flops; there is no clearing
// pass. load_limit (address 0) counts occupied plus tombstoned slots.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [KEY_W-1:0]          in_key,
  input  logic [HASH_W-1:0]         in_key_hash,
  input  logic [VAL_W-1:0]          in_new_value,
  input  logic [START_W-1:0]        in_start_index,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic                      out_is_new_key,
  output logic [VAL_W-1:0]          out_value_out,
  output logic [KEY_W-1:0]          out_key_out,
  output logic signed [NEXT_W-1:0]  out_next_index,
  output logic                      out_table_full,
  output logic [MOD_W-1:0]          out_mod_count,

  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_QUICK,
    S_RUN
  } state_t;

  state_t                  state_r, state_nxt;
  action_t                 act_r, act_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic [VAL_W-1:0]        val_r, val_nxt;
  logic [IDX_W-1:0]        addr_r, addr_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        tomb_r, tomb_nxt;
  logic                    have_tomb_r, have_tomb_nxt;
  logic [UCNT_W-1:0]       used_r, used_nxt;
  logic [MOD_W-1:0]        chg_r, chg_nxt;
  logic [LIMIT_W-1:0]      limit_r, limit_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  logic                    is_new_r, is_new_nxt;
  logic [VAL_W-1:0]        value_out_r, value_out_nxt;
  logic [KEY_W-1:0]        key_out_r, key_out_nxt;
  logic signed [NEXT_W-1:0] next_idx_r, next_idx_nxt;
  logic                    full_r, full_nxt;
  logic [MOD_W-1:0]        mod_r, mod_nxt;

  tag_req_t                tag_req;
  tag_t                    rd_tag;
  logic                    kv_we;
  logic [IDX_W-1:0]        kv_waddr;
  logic [KEY_W+VAL_W-1:0]  kv_rdata;
  logic [KEY_W-1:0]        slot_key;
  logic [VAL_W-1:0]        slot_val;

  action_t                 in_act;
  logic                    quick;
  logic [IDX_W-1:0]        first_addr;
  logic                    out_ready;
  logic                    out_load;
  logic                    cfg_wr;

  logic                    is_used, is_empty, is_tomb, key_hit, last;
  logic                    tomb_now_have;
  logic [IDX_W-1:0]        tomb_now;
  logic [IDX_W-1:0]        free_slot;
  logic                    free_is_empty, hit_free, run_done;

  lpht_tag_store u_tags (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (tag_req),
    .rd_tag (rd_tag)
  );

  lpht_ram #(
    .WIDTH (KEY_W + VAL_W),
    .DEPTH (SLOTS)
  ) u_kv_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (kv_waddr),
    .wdata ({key_r, val_r}),
    .re    (tag_req.rd_en),
    .raddr (tag_req.rd_addr),
    .rdata (kv_rdata)
  );

  assign slot_key = kv_rdata[KEY_W+VAL_W-1:VAL_W];
  assign slot_val = kv_rdata[VAL_W-1:0];

  assign in_act     = action_t'(in_action);
  assign first_addr = (in_act == ACT_ITER) ? in_start_index[IDX_W-1:0]
                                           : in_key_hash[IDX_W-1:0];
  always_comb begin
    case (in_act)
      ACT_GET, ACT_DEL: quick = (used_r == '0);
      ACT_SET:          quick = ((NEXT_W'(used_r) + NEXT_W'(1)) > NEXT_W'(limit_r));
      ACT_ITER:         quick = (32'(in_start_index) >= SLOTS);
      default:          quick = 1'b1;
    endcase
  end

  // probe step on the slot whose tag and key/value just came out of memory
  assign is_used       = (rd_tag == TAG_USED);
  assign is_empty      = (rd_tag == TAG_EMPTY);
  assign is_tomb       = (rd_tag == TAG_TOMB);
  assign key_hit       = is_used && (slot_key == key_r);
  assign last          = (cnt_r == IDX_W'(SLOTS - 1));
  assign tomb_now_have = have_tomb_r || is_tomb;
  assign tomb_now      = have_tomb_r ? tomb_r : addr_r;
  assign free_slot     = tomb_now_have ? tomb_now : addr_r;
  assign free_is_empty = is_empty && !have_tomb_r;
  assign hit_free      = !key_hit && (is_empty || tomb_now_have);
  assign run_done      = (act_r == ACT_ITER) ? (is_used || addr_r == IDX_W'(SLOTS - 1))
                                             : (is_empty || key_hit || last);

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready && !paddr[2];
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? '0 : APB_DW'(limit_r);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    tomb_nxt      = tomb_r;
    have_tomb_nxt = have_tomb_r;
    used_nxt      = used_r;
    chg_nxt       = chg_r;
    limit_nxt     = cfg_wr ? pwdata[LIMIT_W-1:0] : limit_r;
    out_valid_nxt = out_valid_r && out_stall;
    found_nxt     = found_r;
    is_new_nxt    = is_new_r;
    value_out_nxt = value_out_r;
    key_out_nxt   = key_out_r;
    next_idx_nxt  = next_idx_r;
    full_nxt      = full_r;
    mod_nxt       = mod_r;
    tag_req       = '0;
    kv_we         = 1'b0;
    kv_waddr      = addr_r;
    out_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_act;
          key_nxt = in_key;
          val_nxt = in_new_value;
          if (quick) begin
            state_nxt = S_QUICK;
          end else begin
            tag_req.rd_en   = 1'b1;
            tag_req.rd_addr = first_addr;
            addr_nxt        = first_addr;
            cnt_nxt         = '0;
            have_tomb_nxt   = 1'b0;
            state_nxt       = S_RUN;
          end
        end
      end
      S_QUICK: begin
        if (out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          is_new_nxt    = 1'b0;
          value_out_nxt = '0;
          key_out_nxt   = '0;
          next_idx_nxt  = (act_r == ACT_ITER) ? -NEXT_W'(1) : '0;
          full_nxt      = (act_r == ACT_SET);
          mod_nxt       = chg_r;
          state_nxt     = S_IDLE;
        end
      end
      S_RUN: begin
        if (!run_done) begin
          tag_req.rd_en   = 1'b1;
          tag_req.rd_addr = addr_r + IDX_W'(1);
          addr_nxt        = addr_r + IDX_W'(1);
          cnt_nxt         = cnt_r + IDX_W'(1);
          have_tomb_nxt   = tomb_now_have;
          tomb_nxt        = tomb_now;
        end else if (out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          is_new_nxt    = 1'b0;
          value_out_nxt = '0;
          key_out_nxt   = '0;
          next_idx_nxt  = '0;
          full_nxt      = 1'b0;
          state_nxt     = S_IDLE;
          case (act_r)
            ACT_GET: begin
              found_nxt     = key_hit;
              value_out_nxt = key_hit ? slot_val : '0;
            end
            ACT_SET: begin
              if (key_hit) begin
                kv_we    = 1'b1;
                kv_waddr = addr_r;
              end else if (hit_free) begin
                kv_we           = 1'b1;
                kv_waddr        = free_slot;
                tag_req.wr_en   = 1'b1;
                tag_req.wr_addr = free_slot;
                tag_req.wr_tag  = TAG_USED;
                is_new_nxt      = 1'b1;
                if (free_is_empty) begin
                  used_nxt = used_r + UCNT_W'(1);
                  chg_nxt  = chg_r + MOD_W'(1);
                end
              end else begin
                full_nxt = 1'b1;
              end
            end
            ACT_DEL: begin
              if (key_hit) begin
                tag_req.wr_en   = 1'b1;
                tag_req.wr_addr = addr_r;
                tag_req.wr_tag  = TAG_TOMB;
                chg_nxt         = chg_r + MOD_W'(1);
                found_nxt       = 1'b1;
              end
            end
            ACT_ITER: begin
              found_nxt     = is_used;
              key_out_nxt   = is_used ? slot_key : '0;
              value_out_nxt = is_used ? slot_val : '0;
              next_idx_nxt  = is_used ? (NEXT_W'(addr_r) + NEXT_W'(1)) : -NEXT_W'(1);
            end
            default: begin
              found_nxt = 1'b0;
            end
          endcase
          mod_nxt = chg_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      chg_r       <= '0;
      limit_r     <= LIMIT_W'(LIMIT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      chg_r       <= chg_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    addr_r      <= addr_nxt;
    cnt_r       <= cnt_nxt;
    tomb_r      <= tomb_nxt;
    have_tomb_r <= have_tomb_nxt;
    found_r     <= found_nxt;
    is_new_r    <= is_new_nxt;
    value_out_r <= value_out_nxt;
    key_out_r   <= key_out_nxt;
    next_idx_r  <= next_idx_nxt;
    full_r      <= full_nxt;
    mod_r       <= mod_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_is_new_key = is_new_r;
  assign out_value_out  = value_out_r;
  assign out_key_out    = key_out_r;
  assign out_next_index = next_idx_r;
  assign out_table_full = full_r;
  assign out_mod_count  = mod_r;

  `LPHT_ASSERT_IMP(a_used_step, clk, rst_n, $past(rst_n),
    used_r == $past(used_r) || used_r == $past(used_r) + UCNT_W'(1),
    "used count moved by more than one")
  `LPHT_ASSERT_IMP(a_chg_only_on_result, clk, rst_n, $past(rst_n) && !$past(out_load),
    chg_r == $past(chg_r), "change count moved without a result")
  `LPHT_ASSERT_IMP(a_write_with_result, clk, rst_n, tag_req.wr_en || kv_we, out_load,
    "table written without delivering a result")
  `LPHT_ASSERT_IMP(a_probe_bounded, clk, rst_n, state_r == S_RUN && last, run_done,
    "probe ran past a full lap")
  `LPHT_ASSERT(a_used_cap, clk, rst_n, used_r <= UCNT_W'(SLOTS),
    "used count above slot count")

endmodule
